// ===== rtl/rip_relative_load_xref_scanner_macros.svh =====
// Assertion macros for the rip-relative xref scanner.
// Included by the top level; no other dependencies.
`ifndef RIP_RELATIVE_LOAD_XREF_SCANNER_MACROS_SVH
`define RIP_RELATIVE_LOAD_XREF_SCANNER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RRX_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RRX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rrx_pkg.sv =====
// Shared types and constants of the rip-relative xref scanner.
// No dependencies; used by every other file but the macros header.
package rrx_pkg;

   localparam int OFFSET_W   = 32;
   localparam int MAX_W      = 16;
   localparam int MODE_W     = 2;
   localparam int WIN_DEPTH  = 8;
   localparam int FILL_W     = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Transaction kinds on the request channel.
   localparam logic [MODE_W-1:0] MODE_BYTE     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SPAN_END = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SCAN_END = 2'd2;

   // Register index (paddr[2]).
   localparam logic REG_TARGET = 1'b0;
   localparam logic REG_MAX    = 1'b1;

   localparam logic [MAX_W-1:0] MAX_RESET = 16'd64;

   // Instruction encoding.
   localparam logic [7:0] OPC_MOV    = 8'h8B;
   localparam logic [7:0] MODRM_MASK = 8'hC7;
   localparam logic [7:0] MODRM_RIP  = 8'h05;
   localparam logic [7:0] REX_LO     = 8'h40;
   localparam logic [7:0] REX_HI     = 8'h4F;

   // Instruction length minus the window span (start = offset - 8).
   localparam logic [OFFSET_W-1:0] ADJ_SHORT = 32'hFFFF_FFFE; // 6 - 8
   localparam logic [OFFSET_W-1:0] ADJ_LONG  = 32'hFFFF_FFFF; // 7 - 8
   localparam logic [OFFSET_W-1:0] SPAN_BACK = 32'd8;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [7:0]          code_byte;
      logic [OFFSET_W-1:0] byte_offset;
   } req_type;

   typedef struct packed {
      logic                hit;
      logic [OFFSET_W-1:0] start;
   } hit_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] reader_offset;
      logic                reader_valid;
      logic                scan_done;
      logic [OFFSET_W-1:0] total_found;
   } rsp_type;

endpackage

// ===== rtl/rrx_if.sv =====
// Request and response channel interfaces of the rip-relative xref scanner.
// Depends on rrx_pkg.
interface rrx_req_if import rrx_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [7:0]          code_byte;
   logic [OFFSET_W-1:0] byte_offset;

   modport source (output valid, mode, code_byte, byte_offset, input ready);
   modport sink   (input valid, mode, code_byte, byte_offset, output ready);
endinterface

interface rrx_rsp_if import rrx_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] reader_offset;
   logic                reader_valid;
   logic                scan_done;
   logic [OFFSET_W-1:0] total_found;

   modport source (output valid, reader_offset, reader_valid, scan_done, total_found,
                   input ready);
   modport sink   (input valid, reader_offset, reader_valid, scan_done, total_found,
                   output ready);
endinterface

// ===== rtl/rrx_csr.sv =====
// APB-style configuration registers: target offset and report limit.
// Depends on rrx_pkg.
module rrx_csr import rrx_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [OFFSET_W-1:0]   target_offset,
   output logic [MAX_W-1:0]      max_reported
);

   logic [OFFSET_W-1:0] target_ff, target_in;
   logic [MAX_W-1:0]    max_ff, max_in;
   logic                wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      target_in = target_ff;
      max_in    = max_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            REG_TARGET: target_in = csr_pwdata;
            REG_MAX:    max_in    = csr_pwdata[MAX_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_TARGET: csr_prdata = target_ff;
         REG_MAX:    csr_prdata = {{(CSR_DATA_W-MAX_W){1'b0}}, max_ff};
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         max_ff    <= MAX_RESET;
      end else begin
         target_ff <= target_in;
         max_ff    <= max_in;
      end
   end

   assign target_offset = target_ff;
   assign max_reported  = max_ff;

endmodule

// ===== rtl/rrx_window.sv =====
// Eight-byte code window and the rip-relative mov matcher.
// Depends on rrx_pkg.
module rrx_window import rrx_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  req_type             item,
   input  logic [OFFSET_W-1:0] target_offset,
   input  logic [MAX_W-1:0]    max_reported,
   output hit_type             hit_info
);

   logic [7:0]          byte_window_ff [WIN_DEPTH];
   logic [7:0]          byte_window_in [WIN_DEPTH];
   logic [FILL_W-1:0]   window_fill_ff, window_fill_in;
   logic                full;
   logic                form_short, form_long;
   logic [OFFSET_W-1:0] disp, adj, dest;

   assign full = window_fill_ff == FILL_W'(WIN_DEPTH);

   // Short form: 8B modrm disp32. Long form: REX 8B modrm disp32.
   assign form_short = byte_window_ff[0] == OPC_MOV &&
                       (byte_window_ff[1] & MODRM_MASK) == MODRM_RIP;
   assign form_long  = byte_window_ff[0] >= REX_LO && byte_window_ff[0] <= REX_HI &&
                       byte_window_ff[1] == OPC_MOV &&
                       (byte_window_ff[2] & MODRM_MASK) == MODRM_RIP;

   assign disp = form_short ?
                 {byte_window_ff[5], byte_window_ff[4], byte_window_ff[3], byte_window_ff[2]} :
                 {byte_window_ff[6], byte_window_ff[5], byte_window_ff[4], byte_window_ff[3]};
   assign adj  = form_short ? ADJ_SHORT : ADJ_LONG;
   // start + len + disp, with start = offset - 8
   assign dest = item.byte_offset + disp + adj;

   assign hit_info.start = item.byte_offset - SPAN_BACK;
   assign hit_info.hit   = item.mode == MODE_BYTE && full && (form_short || form_long) &&
                           dest == target_offset && target_offset != '0 &&
                           max_reported != '0;

   always_comb begin
      byte_window_in = byte_window_ff;
      window_fill_in = window_fill_ff;
      if (enable) begin
         case (item.mode)
            MODE_BYTE: begin
               if (full) begin
                  for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                     byte_window_in[i] = byte_window_ff[i+1];
                  end
                  byte_window_in[WIN_DEPTH-1] = item.code_byte;
               end else begin
                  byte_window_in[window_fill_ff[FILL_W-2:0]] = item.code_byte;
                  window_fill_in = window_fill_ff + 1'b1;
               end
            end
            MODE_SPAN_END, MODE_SCAN_END: window_fill_in = '0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_fill_ff <= '0;
      end else begin
         window_fill_ff <= window_fill_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_window_ff <= byte_window_in;
   end

endmodule

// ===== rtl/rrx_track.sv =====
// Held hit, record and found counters; forms the response transactions.
// Depends on rrx_pkg.
module rrx_track import rrx_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic [MODE_W-1:0] mode,
   input  hit_type          hit_info,
   input  logic [MAX_W-1:0] max_reported,
   output logic             res_valid,
   output rsp_type          res
);

   logic [OFFSET_W-1:0] held_offset_ff, held_offset_in;
   logic                held_valid_ff, held_valid_in;
   logic [MAX_W-1:0]    recorded_ff, recorded_in;
   logic [OFFSET_W-1:0] found_ff, found_in;
   logic                adjacent;

   // A hit right after the held one means the held hit took a stray REX byte.
   assign adjacent = held_valid_ff && held_offset_ff == hit_info.start - 1'b1;

   always_comb begin
      held_offset_in = held_offset_ff;
      held_valid_in  = held_valid_ff;
      recorded_in    = recorded_ff;
      found_in       = found_ff;
      res_valid      = 1'b0;
      res            = '0;
      if (enable) begin
         case (mode)
            MODE_SCAN_END: begin
               res_valid         = 1'b1;
               res.reader_offset = held_valid_ff ? held_offset_ff : '0;
               res.reader_valid  = held_valid_ff;
               res.scan_done     = 1'b1;
               res.total_found   = found_ff;
               held_offset_in    = '0;
               held_valid_in     = 1'b0;
               recorded_in       = '0;
               found_in          = '0;
            end
            MODE_BYTE: begin
               if (hit_info.hit) begin
                  if (adjacent) begin
                     held_offset_in = hit_info.start;
                  end else begin
                     if (found_ff != '1) begin
                        found_in = found_ff + 1'b1;
                     end
                     if (recorded_ff < max_reported) begin
                        res_valid         = held_valid_ff;
                        res.reader_offset = held_offset_ff;
                        res.reader_valid  = 1'b1;
                        held_offset_in    = hit_info.start;
                        held_valid_in     = 1'b1;
                        recorded_in       = recorded_ff + 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_offset_ff <= '0;
         held_valid_ff  <= 1'b0;
         recorded_ff    <= '0;
         found_ff       <= '0;
      end else begin
         held_offset_ff <= held_offset_in;
         held_valid_ff  <= held_valid_in;
         recorded_ff    <= recorded_in;
         found_ff       <= found_in;
      end
   end

endmodule

// ===== rtl/rip_relative_load_xref_scanner.sv =====
// Rip-relative load xref scanner.
// req_ch carries one code byte per transaction (mode 0) with its image offset,
// or a span end (mode 1) or a scan end (mode 2); mode 3 is dropped silently.
// rsp_ch carries reader offsets of 32-bit rip-relative movs that hit
// target_offset, one hit late, and one scan-done transaction with the
// saturating total count at each scan end.
// An accepted request is held in the input register and processed when it
// advances; its response, if any, is then registered in the response register.
// Throughput: one request per cycle while rsp_ch does not stall. The input
// register feeds one pass of window match, one 32-bit add/compare and the
// hit tracker into the response register.
// When rsp_ch stalls, the full response register holds its transaction and
// the input register keeps the next request; req_ch.ready drops only when
// both are occupied.
// Reset (synchronous, active high) empties both registers and the window, clears the
// held hit and counters, and sets target_offset to 0 and max_reported to 64.
// The configuration port is APB-style: target at 0x0, limit at 0x4.
// Depends on rrx_pkg, rrx_if, rrx_csr, rrx_window, rrx_track and the macros header.
`include "rip_relative_load_xref_scanner_macros.svh"

module rip_relative_load_xref_scanner import rrx_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   rrx_req_if.sink               req_ch,
   rrx_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [OFFSET_W-1:0] target_offset;
   logic [MAX_W-1:0]    max_reported;

   // input register
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_ff, s1_in;
   // response register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;

   logic    out_free, advance, accept;
   hit_type hit_info;
   logic    res_valid;
   rsp_type res;

   rrx_csr u_csr (
      .clock, .reset,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready,
      .target_offset, .max_reported
   );

   // Handshake: the response register frees when taken, so the pipe keeps
   // moving even while a result is waiting for the same edge.
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign advance      = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      s1_in       = s1_ff;
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_in.mode        = req_ch.mode;
         s1_in.code_byte   = req_ch.code_byte;
         s1_in.byte_offset = req_ch.byte_offset;
         s1_valid_in       = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   rrx_window u_window (
      .clock, .reset,
      .enable(advance),
      .item(s1_ff),
      .target_offset, .max_reported,
      .hit_info
   );

   rrx_track u_track (
      .clock, .reset,
      .enable(advance),
      .mode(s1_ff.mode),
      .hit_info, .max_reported,
      .res_valid, .res
   );

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (advance && res_valid) begin
         out_in       = res;
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      out_ff <= out_in;
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.reader_offset = out_ff.reader_offset;
   assign rsp_ch.reader_valid  = out_ff.reader_valid;
   assign rsp_ch.scan_done     = out_ff.scan_done;
   assign rsp_ch.total_found   = out_ff.total_found;

   // ---- assertions ----
   `RRX_ASSERT(a_flow_out_free, clock, reset, s1_valid_ff && !out_valid_ff, req_ch.ready, "request stalled with free response register")
   `RRX_ASSERT_NEXT(a_scan_end_reports, clock, reset, advance && s1_ff.mode == MODE_SCAN_END, out_valid_ff && out_ff.scan_done, "scan end produced no done transaction")
   `RRX_ASSERT(a_no_reader_zero, clock, reset, rsp_ch.valid && !rsp_ch.reader_valid, rsp_ch.reader_offset == '0, "reader offset set without a reader")
   `RRX_ASSERT(a_mid_scan_shape, clock, reset, rsp_ch.valid && !rsp_ch.scan_done, rsp_ch.reader_valid && rsp_ch.total_found == '0, "mid-scan transaction without a reader")

endmodule
